### rtl/byte_ring_fifo_with_snapshot_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the byte ring FIFO.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_SNAPSHOT_MACROS_SVH
`define BYTE_RING_FIFO_WITH_SNAPSHOT_MACROS_SVH

// same-cycle implication
`define BRF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Types and constants for the byte ring FIFO with pointer snapshot.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 11;
  localparam int ACT_W   = 2;

  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SAVE    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RESTORE = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] write_byte;
    logic              burst_end;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               accepted;
    logic [LEVEL_W-1:0] fill_level;
    logic               is_full;
    logic               is_empty;
    logic               last;
  } result_t;

  // result fields known at access time; the byte follows from memory
  typedef struct packed {
    logic               rd_taken;
    logic               accepted;
    logic [LEVEL_W-1:0] fill_level;
    logic               is_full;
    logic               is_empty;
    logic               last;
  } meta_t;

endpackage

### rtl/byte_ring_fifo_with_snapshot.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_snapshot
// Circular byte FIFO with pointer save/restore and a registered result port.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result side keeps up; each gives
// one result via the stage register, then the output register. The single-port
// byte store does at most one access per transaction (write or read), which sets
// the one-per-cycle pace. item_stall rises only while both the stage register and
// the output register hold results and the result side stalls. A ring_length
// write empties the FIFO and drops any saved snapshot; cfg_ready is always high.
module byte_ring_fifo_with_snapshot
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result
);

  localparam int PTR_W = $clog2(DEPTH);

  logic              item_fire;
  logic              mem_en, mem_we;
  logic [PTR_W-1:0]  mem_addr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  meta_t             meta, s1_meta;
  logic              s1_valid, s1_move;

  assign cfg_ready  = 1'b1;
  assign s1_move    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_move;
  assign item_fire  = item_valid && !item_stall;

  brf_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .item_fire (item_fire),
    .item      (item),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .meta      (meta)
  );

  brf_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= item_fire || (s1_valid && !s1_move);
      if (s1_move) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_meta <= meta;
    end
    if (s1_move) begin
      result.read_byte  <= s1_meta.rd_taken ? mem_rdata : '0;
      result.accepted   <= s1_meta.accepted;
      result.fill_level <= s1_meta.fill_level;
      result.is_full    <= s1_meta.is_full;
      result.is_empty   <= s1_meta.is_empty;
      result.last       <= s1_meta.last;
    end
  end

endmodule

### rtl/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// Single-port byte store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module brf_ram
  import brf_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Pointer, level and snapshot state; decodes one transaction per cycle.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_with_snapshot_macros.svh"

module brf_ctrl
  import brf_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int PTR_W = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LEVEL_W-1:0] cfg_data,
  input  logic               item_fire,
  input  item_t              item,
  output logic               mem_en,
  output logic               mem_we,
  output logic [PTR_W-1:0]   mem_addr,
  output logic [BYTE_W-1:0]  mem_wdata,
  output meta_t              meta
);

  localparam int CMP_W = ((PTR_W > LEVEL_W) ? PTR_W : LEVEL_W) + 1;
  localparam logic [LEVEL_W-1:0] RESET_LEN =
    LEVEL_W'((DEPTH < 1024) ? DEPTH : 1024);

  logic [LEVEL_W-1:0] len, len_next;
  logic [PTR_W-1:0]   wr_ptr, rd_ptr, wr_ptr_next, rd_ptr_next;
  logic [LEVEL_W-1:0] level, level_next, level_inc;
  logic               full, full_next;
  logic [PTR_W-1:0]   sv_wr_ptr, sv_rd_ptr;
  logic [LEVEL_W-1:0] sv_level;
  logic               sv_full, sv_valid;
  logic [CMP_W-1:0]   wr_inc, rd_inc;
  logic               ok;

  always_comb begin
    if (cfg_data == '0) begin
      len_next = LEVEL_W'(1);
    end else if (32'(cfg_data) > DEPTH) begin
      len_next = LEVEL_W'(DEPTH);
    end else begin
      len_next = cfg_data;
    end
  end

  assign level_inc = level + 1'b1;
  assign wr_inc    = CMP_W'(wr_ptr) + 1'b1;
  assign rd_inc    = CMP_W'(rd_ptr) + 1'b1;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    level_next  = level;
    full_next   = full;
    ok          = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = wr_ptr;
    unique case (item.action)
      ACT_WRITE: begin
        if (level < len) begin
          ok          = 1'b1;
          mem_en      = item_fire;
          mem_we      = 1'b1;
          wr_ptr_next = (wr_inc >= CMP_W'(len)) ? '0 : wr_inc[PTR_W-1:0];
          level_next  = level_inc;
          full_next   = (level_inc >= len);
        end
      end
      ACT_READ: begin
        mem_addr = rd_ptr;
        if (level != '0) begin
          ok          = 1'b1;
          mem_en      = item_fire;
          rd_ptr_next = (rd_inc >= CMP_W'(len)) ? '0 : rd_inc[PTR_W-1:0];
          level_next  = level - 1'b1;
          full_next   = 1'b0;
        end
      end
      ACT_SAVE: begin
        ok = 1'b1;
      end
      ACT_RESTORE: begin
        if (sv_valid) begin
          ok          = 1'b1;
          wr_ptr_next = sv_wr_ptr;
          rd_ptr_next = sv_rd_ptr;
          level_next  = sv_level;
          full_next   = sv_full;
        end
      end
      default: ;
    endcase
  end

  assign mem_wdata       = item.write_byte;
  assign meta.rd_taken   = ok && (item.action == ACT_READ);
  assign meta.accepted   = ok;
  assign meta.fill_level = level_next;
  assign meta.is_full    = full_next;
  assign meta.is_empty   = (level_next == '0);
  assign meta.last       = item.burst_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= RESET_LEN;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      level     <= '0;
      full      <= 1'b0;
      sv_wr_ptr <= '0;
      sv_rd_ptr <= '0;
      sv_level  <= '0;
      sv_full   <= 1'b0;
      sv_valid  <= 1'b0;
    end else if (cfg_we) begin
      len      <= len_next;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      level    <= '0;
      full     <= 1'b0;
      sv_valid <= 1'b0;
    end else if (item_fire) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
      full   <= full_next;
      if (item.action == ACT_SAVE) begin
        sv_wr_ptr <= wr_ptr;
        sv_rd_ptr <= rd_ptr;
        sv_level  <= level;
        sv_full   <= full;
        sv_valid  <= 1'b1;
      end
    end
  end

  `BRF_ASSERT_IMPL(a_level_bound, clk, rst, 1'b1, level <= len, "level above ring length")
  `BRF_ASSERT_IMPL(a_full_match, clk, rst, 1'b1, full == (level == len), "full flag mismatch")
  `BRF_ASSERT_IMPL(a_ptr_bound, clk, rst, 1'b1,
    (CMP_W'(wr_ptr) < CMP_W'(len)) && (CMP_W'(rd_ptr) < CMP_W'(len)), "pointer out of ring")
  `BRF_ASSERT_NEXT(a_write_level, clk, rst,
    item_fire && !cfg_we && mem_en && mem_we, level == $past(level_inc), "write level step")
  `BRF_ASSERT_IMPL(a_ram_access, clk, rst, mem_en, item_fire && ok, "stray memory access")

endmodule
